### sv/stt_pkg.sv
// Shared types, codes and sizes of the software timer table.
package stt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int ID_W       = 4;
  localparam int IVAL_W     = 32;
  localparam int TIME_W     = 64;
  localparam int TMO_W      = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POLL    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd4;

  localparam logic [TMO_W-2:0] INT_MAX  = 31'h7FFF_FFFF;
  localparam logic [TMO_W-1:0] TMO_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_adv;
    logic emit_final;
  } stt_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] in_cmd;
    logic             out_free;
    logic             stall;
    logic             scan_end;
  } stt_sts_t;

endpackage

### sv/software_timer_table.sv
// Top level of the software timer table: sequencer and slot datapath.
// Create, cancel, restart and unknown commands pass from transfer through the execute state to the result register.
// Query and poll scan the slot table one slot per cycle while not stalled, then place a final result.
// A poll stalls its scan while a fired result waits on the output register.
// A new command is taken once the previous one has placed its last result.
// Synchronous reset clears the live and armed flags of every slot at once.
module software_timer_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd
  input  logic [stt_pkg::CMD_W-1:0]           in_tuser,
  // slot, interval, repeat_mode, now_ms, zero fill
  input  logic [stt_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // slot_id, timeout_ms, zero fill
  output logic [stt_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [stt_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                out_tlast
);

  stt_pkg::stt_ctl_t ctl;
  stt_pkg::stt_sts_t sts;

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  stt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/stt_ctrl.sv
// Command sequencer of the software timer table.
module stt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  stt_pkg::stt_sts_t sts,
  output stt_pkg::stt_ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctl.accept = 1'b1;
          if (sts.in_cmd inside {stt_pkg::CMD_QUERY, stt_pkg::CMD_POLL}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.stall) begin
          ctl.scan_adv = 1'b1;
          if (sts.scan_end) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/stt_dp.sv
// Slot storage, scan arithmetic and result register of the software timer table.
module stt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [stt_pkg::CMD_W-1:0]           in_tuser,
  input  logic [stt_pkg::IN_DATA_W-1:0]       in_tdata,
  input  stt_pkg::stt_ctl_t                   ctl,
  output stt_pkg::stt_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [stt_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                out_tlast
);

  logic [stt_pkg::CMD_W-1:0]  in_cmd;
  logic [stt_pkg::ID_W-1:0]   in_slot;
  logic [stt_pkg::IVAL_W-1:0] in_ival;
  logic                       in_rep;
  logic [stt_pkg::TIME_W-1:0] in_now;

  logic [stt_pkg::CMD_W-1:0]  cmd_r;
  logic [stt_pkg::ID_W-1:0]   slot_r;
  logic [stt_pkg::IVAL_W-1:0] ival_r;
  logic                       rep_r;
  logic [stt_pkg::TIME_W-1:0] now_r;

  logic [stt_pkg::SLOTS-1:0]  live_r;
  logic [stt_pkg::SLOTS-1:0]  armed_r;
  logic [stt_pkg::SLOTS-1:0]  slot_rep_r;
  logic [stt_pkg::IVAL_W-1:0] interval_mem [stt_pkg::SLOTS];
  logic [stt_pkg::TIME_W-1:0] deadline_mem [stt_pkg::SLOTS];
  logic [stt_pkg::IVAL_W-1:0] rd_ival_r;
  logic [stt_pkg::TIME_W-1:0] rd_dl_r;

  logic [stt_pkg::SLOT_W-1:0] idx_r;
  logic                       any_r;
  logic                       due_r;
  logic [stt_pkg::TMO_W-2:0]  best_r;
  logic                       pend_valid_r;
  logic [stt_pkg::ID_W-1:0]   pend_slot_r;

  logic                         out_valid_r;
  logic [stt_pkg::STATUS_W-1:0] out_status_r;
  logic [stt_pkg::ID_W-1:0]     out_slot_r;
  logic [stt_pkg::TMO_W-1:0]    out_tmo_r;
  logic                         out_last_r;

  logic                         out_free;
  logic                         act;
  logic [stt_pkg::TIME_W:0]     diff;
  logic                         due;
  logic                         fire;
  logic [stt_pkg::TMO_W-2:0]    d_cl;
  logic                         free_found;
  logic [stt_pkg::SLOT_W-1:0]   free_idx;
  logic [stt_pkg::IVAL_W-1:0]   ival_f;
  logic                         slot_ok;
  logic [stt_pkg::SLOT_W-1:0]   slot_idx;
  logic [stt_pkg::IVAL_W-1:0]   add_op;
  logic [stt_pkg::TIME_W-1:0]   sum;
  logic                         create_do;
  logic                         cancel_do;
  logic                         restart_do;
  logic                         poll_rep_do;
  logic                         poll_disarm_do;
  logic                         dl_we;
  logic [stt_pkg::SLOT_W-1:0]   dl_addr;
  logic [stt_pkg::SLOT_W-1:0]   rd_addr;

  logic                         emit;
  logic [stt_pkg::STATUS_W-1:0] e_status;
  logic [stt_pkg::ID_W-1:0]     e_slot;
  logic [stt_pkg::TMO_W-1:0]    e_tmo;
  logic                         e_last;

  assign in_cmd  = in_tuser;
  assign in_slot = in_tdata[3:0];
  assign in_ival = in_tdata[35:4];
  assign in_rep  = in_tdata[36];
  assign in_now  = in_tdata[100:37];

  assign out_free = !out_valid_r || out_tready;

  // A slot is due when its deadline is at or before the time of the command.
  assign act  = live_r[idx_r] && armed_r[idx_r];
  assign diff = {1'b0, rd_dl_r} - {1'b0, now_r};
  assign due  = act && (diff[stt_pkg::TIME_W] || (diff[stt_pkg::TIME_W-1:0] == '0));
  assign fire = (cmd_r == stt_pkg::CMD_POLL) && due;
  assign d_cl = (|diff[stt_pkg::TIME_W-1:stt_pkg::TMO_W-1]) ? stt_pkg::INT_MAX
                                                            : diff[stt_pkg::TMO_W-2:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = stt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_found = 1'b1;
        free_idx   = stt_pkg::SLOT_W'(i);
      end
    end
  end

  assign ival_f   = (rep_r && (ival_r == '0)) ? stt_pkg::IVAL_W'(1) : ival_r;
  assign slot_ok  = (32'(slot_r) < stt_pkg::SLOTS);
  assign slot_idx = slot_r[stt_pkg::SLOT_W-1:0];
  assign add_op   = (cmd_r == stt_pkg::CMD_CREATE) ? ival_f : rd_ival_r;
  assign sum      = now_r + {{(stt_pkg::TIME_W - stt_pkg::IVAL_W){1'b0}}, add_op};

  assign create_do      = ctl.exec && (cmd_r == stt_pkg::CMD_CREATE) && free_found;
  assign cancel_do      = ctl.exec && (cmd_r == stt_pkg::CMD_CANCEL) && slot_ok;
  assign restart_do     = ctl.exec && (cmd_r == stt_pkg::CMD_RESTART) && slot_ok &&
                          live_r[slot_idx];
  assign poll_rep_do    = ctl.scan_adv && fire && slot_rep_r[idx_r];
  assign poll_disarm_do = ctl.scan_adv && fire && !slot_rep_r[idx_r];

  always_comb begin
    dl_we   = create_do || restart_do || poll_rep_do;
    dl_addr = idx_r;
    if (create_do) begin
      dl_addr = free_idx;
    end else if (restart_do) begin
      dl_addr = slot_idx;
    end
  end

  always_comb begin
    if (ctl.accept) begin
      rd_addr = (in_cmd == stt_pkg::CMD_RESTART) ? in_slot[stt_pkg::SLOT_W-1:0] : '0;
    end else if (ctl.scan_adv) begin
      rd_addr = idx_r + 1'b1;
    end else begin
      rd_addr = idx_r;
    end
  end

  assign sts.in_cmd   = in_cmd;
  assign sts.out_free = out_free;
  assign sts.stall    = fire && pend_valid_r && !out_free;
  assign sts.scan_end = (idx_r == stt_pkg::SLOT_W'(stt_pkg::SLOTS - 1));

  always_comb begin
    emit     = 1'b0;
    e_status = stt_pkg::ST_DONE;
    e_slot   = '0;
    e_tmo    = '0;
    e_last   = 1'b1;
    if (ctl.exec) begin
      emit = 1'b1;
      case (cmd_r)
        stt_pkg::CMD_CREATE: begin
          if (free_found) begin
            e_slot = stt_pkg::ID_W'(free_idx);
          end else begin
            e_status = stt_pkg::ST_NOSLOT;
          end
        end
        stt_pkg::CMD_CANCEL, stt_pkg::CMD_RESTART: begin
          e_slot = slot_r;
        end
        default: begin
          e_slot = '0;
        end
      endcase
    end else if (ctl.scan_adv && fire && pend_valid_r) begin
      emit     = 1'b1;
      e_status = stt_pkg::ST_FIRED;
      e_slot   = pend_slot_r;
      e_last   = 1'b0;
    end else if (ctl.emit_final) begin
      emit = 1'b1;
      if (cmd_r == stt_pkg::CMD_QUERY) begin
        e_status = stt_pkg::ST_TIMEOUT;
        if (due_r) begin
          e_tmo = '0;
        end else if (any_r) begin
          e_tmo = {1'b0, best_r};
        end else begin
          e_tmo = stt_pkg::TMO_NONE;
        end
      end else if (pend_valid_r) begin
        e_status = stt_pkg::ST_FIRED;
        e_slot   = pend_slot_r;
      end else begin
        e_status = stt_pkg::ST_NOTHING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      armed_r      <= '0;
      idx_r        <= '0;
      any_r        <= 1'b0;
      due_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.accept) begin
        idx_r        <= (in_cmd == stt_pkg::CMD_RESTART) ? in_slot[stt_pkg::SLOT_W-1:0] : '0;
        any_r        <= 1'b0;
        due_r        <= 1'b0;
        pend_valid_r <= 1'b0;
      end else if (ctl.scan_adv) begin
        idx_r <= idx_r + 1'b1;
        if ((cmd_r == stt_pkg::CMD_QUERY) && act) begin
          if (due) begin
            due_r <= 1'b1;
          end else begin
            any_r <= 1'b1;
          end
        end
        if (fire) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (create_do) begin
        live_r[free_idx]  <= 1'b1;
        armed_r[free_idx] <= 1'b1;
      end
      if (cancel_do) begin
        live_r[slot_idx]  <= 1'b0;
        armed_r[slot_idx] <= 1'b0;
      end
      if (restart_do) begin
        armed_r[slot_idx] <= 1'b1;
      end
      if (poll_disarm_do) begin
        armed_r[idx_r] <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
      ival_r <= in_ival;
      rep_r  <= in_rep;
      now_r  <= in_now;
    end
    if (ctl.scan_adv && (cmd_r == stt_pkg::CMD_QUERY) && act && !due) begin
      if (!any_r || (d_cl < best_r)) begin
        best_r <= d_cl;
      end
    end
    if (ctl.scan_adv && fire) begin
      pend_slot_r <= stt_pkg::ID_W'(idx_r);
    end
    if (create_do) begin
      slot_rep_r[free_idx] <= rep_r;
    end
    if (emit) begin
      out_status_r <= e_status;
      out_slot_r   <= e_slot;
      out_tmo_r    <= e_tmo;
      out_last_r   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_mem[dl_addr] <= sum;
    end
    if (create_do) begin
      interval_mem[free_idx] <= ival_f;
    end
    rd_ival_r <= interval_mem[rd_addr];
    rd_dl_r   <= deadline_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(stt_pkg::OUT_DATA_W - stt_pkg::ID_W - stt_pkg::TMO_W){1'b0}},
                       out_tmo_r, out_slot_r};

endmodule

### sv/stt_checker.sv
// Port-level checks of the software timer table and their binding.
module stt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [stt_pkg::CMD_W-1:0]      in_tuser,
  input logic [stt_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [stt_pkg::STATUS_W-1:0]   out_tuser,
  input logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("Result changed while stalled.");

  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == stt_pkg::ST_TIMEOUT) |->
      out_tlast && (out_tdata[3:0] == 4'd0) &&
      (!out_tdata[35] || (out_tdata[35:4] == stt_pkg::TMO_NONE)))
    else $error("Timeout report is malformed.");

  a_single_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == stt_pkg::ST_NOSLOT) || (out_tuser == stt_pkg::ST_NOTHING)) |->
      out_tlast && (out_tdata[35:0] == 36'd0))
    else $error("No-slot or nothing-due result is malformed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Block is not idle after reset.");

endmodule

bind software_timer_table stt_checker u_stt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### dv/software_timer_table_checker.sv
`timescale 1ns / 100ps
// Checker for the software timer table that predicts each command's results and compares them.
module software_timer_table_checker
  import stt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // cmd
  input  logic [CMD_W-1:0]      in_tuser,
  // slot, interval, repeat_mode, now_ms, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // slot_id, timeout_ms, zero fill
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // status
  input  logic [STATUS_W-1:0]   out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen,
  output int                    fired_seen
);

  localparam int MAX_FIRE = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     slot_id;
    logic [TMO_W-1:0]    timeout_ms;
    logic                last;
  } timer_result_t;

  timer_result_t    awaited_results[$];
  logic             live     [SLOTS];
  logic             armed    [SLOTS];
  logic             periodic [SLOTS];
  logic [IVAL_W-1:0] interval [SLOTS];
  logic [TIME_W-1:0] deadline [SLOTS];

  task automatic add_result(input logic [STATUS_W-1:0] status, input logic [ID_W-1:0] id,
                            input logic [TMO_W-1:0] tmo);
    timer_result_t r;
    r.status     = status;
    r.slot_id    = id;
    r.timeout_ms = tmo;
    r.last       = 1'b0;
    awaited_results.push_back(r);
  endtask

  task automatic run_timer_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                   input logic [IVAL_W-1:0] ival, input logic rep,
                                   input logic [TIME_W-1:0] now);
    int            free_slot;
    int            fired;
    logic          any_armed;
    logic          any_due;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] least;
    timer_result_t tail;
    free_slot = -1;
    fired     = 0;
    any_armed = 1'b0;
    any_due   = 1'b0;
    least     = '0;
    case (cmd)
      CMD_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!live[i]) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot < 0) begin
          add_result(ST_NOSLOT, '0, '0);
        end else begin
          if (rep && ival == '0) ival = IVAL_W'(1);
          live[free_slot]     = 1'b1;
          armed[free_slot]    = 1'b1;
          periodic[free_slot] = rep;
          interval[free_slot] = ival;
          deadline[free_slot] = now + TIME_W'(ival);
          add_result(ST_DONE, ID_W'(free_slot), '0);
        end
      end
      CMD_CANCEL: begin
        live[slot]  = 1'b0;
        armed[slot] = 1'b0;
        add_result(ST_DONE, ID_W'(slot), '0);
      end
      CMD_RESTART: begin
        if (live[slot]) begin
          deadline[slot] = now + TIME_W'(interval[slot]);
          armed[slot]    = 1'b1;
        end
        add_result(ST_DONE, ID_W'(slot), '0);
      end
      CMD_QUERY: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!live[i] || !armed[i]) continue;
          if (deadline[i] <= now) begin
            any_due = 1'b1;
            break;
          end
          remaining = deadline[i] - now;
          if (remaining > TIME_W'(INT_MAX)) remaining = TIME_W'(INT_MAX);
          if (!any_armed || remaining < least) least = remaining;
          any_armed = 1'b1;
        end
        if (any_due) add_result(ST_TIMEOUT, '0, '0);
        else if (any_armed) add_result(ST_TIMEOUT, '0, least[TMO_W-1:0]);
        else add_result(ST_TIMEOUT, '0, TMO_NONE);
      end
      CMD_POLL: begin
        for (int i = 0; i < SLOTS && fired < MAX_FIRE; i++) begin
          if (!live[i] || !armed[i] || deadline[i] > now) continue;
          if (periodic[i]) deadline[i] = now + TIME_W'(interval[i]);
          else armed[i] = 1'b0;
          add_result(ST_FIRED, ID_W'(i), '0);
          fired++;
        end
        if (fired == 0) add_result(ST_NOTHING, '0, '0);
      end
      default: begin
        add_result(ST_DONE, '0, '0);
      end
    endcase
    tail = awaited_results.pop_back();
    tail.last = 1'b1;
    awaited_results.push_back(tail);
  endtask

  task automatic check_field(input string name, input logic [TMO_W-1:0] want,
                             input logic [TMO_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      awaited_results.delete();
      for (int i = 0; i < SLOTS; i++) begin
        live[i]  = 1'b0;
        armed[i] = 1'b0;
      end
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser == ST_FIRED) fired_seen++;
        if (awaited_results.size() == 0) begin
          $error("Result transfer with nothing expected: status %0d, slot_id %0d",
                 out_tuser, out_tdata[ID_W-1:0]);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", TMO_W'(want.status), TMO_W'(out_tuser));
          check_field("slot_id", TMO_W'(want.slot_id), TMO_W'(out_tdata[ID_W-1:0]));
          check_field("timeout_ms", want.timeout_ms, out_tdata[ID_W +: TMO_W]);
          check_field("last", TMO_W'(want.last), TMO_W'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        run_timer_command(in_tuser, in_tdata[SLOT_W-1:0], in_tdata[SLOT_W +: IVAL_W],
                          in_tdata[SLOT_W + IVAL_W], in_tdata[SLOT_W + IVAL_W + 1 +: TIME_W]);
      end
      pending <= awaited_results.size();
    end
  end

endmodule

### dv/software_timer_table_test.sv
`timescale 1ns / 100ps
// Testbench top for the software timer table with clock, reset, stimulus and verdict.
module software_timer_table_test;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 76;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_POLL + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;

  int                fail_count;
  int                pending;
  int                results_seen;
  int                fired_seen;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                cycle_count;
  int                commands_sent;
  bit                hold_req;
  bit                hold_done;
  logic [TIME_W-1:0] clock_ms;

  software_timer_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  software_timer_table_checker timer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .fired_seen   (fired_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result side stalls at random, and once holds off for a long stretch.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                              input logic [IVAL_W-1:0] ival, input logic rep,
                              input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({now, rep, ival, slot});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic random_command();
    int                pick;
    logic [CMD_W-1:0]  cmd;
    logic [IVAL_W-1:0] ival;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(0, 99);
    if (pick < 25) cmd = CMD_CREATE;
    else if (pick < 42) cmd = CMD_CANCEL;
    else if (pick < 57) cmd = CMD_RESTART;
    else if (pick < 70) cmd = CMD_QUERY;
    else if (pick < 95) cmd = CMD_POLL;
    else cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    clock_ms += $urandom_range(0, 15);
    now = clock_ms;
    if ($urandom_range(0, 99) < 4) now = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 8) ival = $urandom;
    else if (pick < 11) ival = '1;
    else ival = $urandom_range(0, 40);
    send_command(cmd, SLOT_W'($urandom_range(0, SLOTS - 1)), ival, 1'($urandom_range(0, 1)),
                 now);
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tuser    = '0;
    in_tdata    = '0;
    rst_n       = 1'b0;
    tx_idle_pct = 13;
    rx_idle_pct = 75;
    clock_ms    = 1000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An empty table, zero intervals, clamped timeouts, wrapped deadlines, slots that are
    // not live, unused command codes and a full table.
    send_command(CMD_QUERY, '0, '0, 1'b0, clock_ms);
    send_command(CMD_POLL, '0, '0, 1'b0, clock_ms);
    send_command(CMD_CREATE, '0, '0, 1'b0, clock_ms);
    send_command(CMD_CREATE, '0, '0, 1'b1, clock_ms);
    send_command(CMD_QUERY, '0, '0, 1'b0, clock_ms);
    send_command(CMD_POLL, '0, '0, 1'b0, clock_ms);
    send_command(CMD_QUERY, '0, '0, 1'b0, clock_ms);
    send_command(CMD_CREATE, '0, '1, 1'b1, clock_ms);
    send_command(CMD_CREATE, '0, 32'h7FFF_FFFF, 1'b0, clock_ms);
    send_command(CMD_CANCEL, 4'd1, '0, 1'b0, clock_ms);
    send_command(CMD_QUERY, '0, '0, 1'b0, clock_ms + 1);
    send_command(CMD_CREATE, '0, 32'h8000_0000, 1'b0, clock_ms);
    send_command(CMD_RESTART, '0, '0, 1'b0, clock_ms + 50);
    send_command(CMD_RESTART, 4'd14, '0, 1'b0, clock_ms);
    send_command(CMD_CANCEL, 4'd15, '0, 1'b0, clock_ms);
    send_command(CMD_CREATE, '0, 32'h20, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
    send_command(CMD_QUERY, '0, '0, 1'b0, clock_ms);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      send_command(CMD_W'(c), '1, $urandom, 1'b1, {$urandom, $urandom});
    end
    repeat (12) send_command(CMD_CREATE, '0, IVAL_W'($urandom_range(0, 5)), 1'b0, clock_ms);
    clock_ms += 100;
    send_command(CMD_POLL, '0, '0, 1'b0, clock_ms);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 75 : 0;
      rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 13 : 0;
      if (phase == 2) hold_req = 1'b1;
      repeat (RANDOM_PER_PHASE) random_command();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands over three stall patterns and one long output hold.",
             commands_sent);
    $display("Checked %0d results, %0d of them timer expirations.", results_seen, fired_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
